@@ rtl/bqlp_pkg.sv @@
// shared types, codes and constants for the biquad low-pass filter
`timescale 1ns / 1ps

package bqlp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 32;
    localparam int GAIN_W     = 24;
    localparam int GAIN_FRAC  = 16;
    localparam int HIST_W     = 48;
    localparam int Y_SPLIT    = 24;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 25;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    // covers the feedback products plus feedforward terms at the widest history format
    localparam int ACC_W      = 84;
    localparam int OUT_LIMIT  = 32765;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PC_W       = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN = 3'd4;

    localparam logic signed [COEF_W-1:0] RST_COEF_A0 = 32'sd1269807;
    localparam logic signed [COEF_W-1:0] RST_COEF_A1 = 32'sd2539614;
    localparam logic signed [COEF_W-1:0] RST_COEF_B1 = -32'sd496202096;
    localparam logic signed [COEF_W-1:0] RST_COEF_B2 = 32'sd232845826;
    localparam logic [GAIN_W-1:0]        RST_GAIN    = 24'd65536;

    // program addresses with a special role
    localparam logic [PC_W-1:0] STEP_WAIT = 4'd0;
    localparam logic [PC_W-1:0] STEP_EMIT = 4'd15;

    typedef enum logic [1:0] {
        COND_NONE = 2'd0,
        COND_IN   = 2'd1,
        COND_OUT  = 2'd2
    } cond_t;

    typedef enum logic [2:0] {
        MA_A0   = 3'd0,
        MA_A1   = 3'd1,
        MA_B1   = 3'd2,
        MA_B2   = 3'd3,
        MA_GAIN = 3'd4
    } mul_a_t;

    typedef enum logic [3:0] {
        MB_X     = 4'd0,
        MB_X1    = 4'd1,
        MB_X2    = 4'd2,
        MB_Y1_LO = 4'd3,
        MB_Y1_HI = 4'd4,
        MB_Y2_LO = 4'd5,
        MB_Y2_HI = 4'd6,
        MB_YN_LO = 4'd7,
        MB_YN_HI = 4'd8
    } mul_b_t;

    typedef enum logic [2:0] {
        ACC_NOP   = 3'd0,
        ACC_LOAD  = 3'd1,
        ACC_ADD   = 3'd2,
        ACC_SUB   = 3'd3,
        ACC_RND_Y = 3'd4,
        ACC_RND_O = 3'd5
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_NONE = 2'd0,
        SH_HIST = 2'd1,
        SH_HALF = 2'd2
    } shift_t;

    typedef struct packed {
        cond_t   cond;
        logic    jump;
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        shift_t  shift;
        logic    sat_y;
        logic    emit;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        cond:   COND_NONE,
        jump:   1'b0,
        mul_en: 1'b0,
        mul_a:  MA_A0,
        mul_b:  MB_X,
        acc_op: ACC_NOP,
        shift:  SH_NONE,
        sat_y:  1'b0,
        emit:   1'b0
    };

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic [GAIN_W-1:0]        gain;
    } cfg_t;

endpackage

@@ rtl/bqlp_ucode_rom.sv @@
// microprogram table: one control word per step
`timescale 1ns / 1ps

module bqlp_ucode_rom (
    input  logic [bqlp_pkg::PC_W-1:0] pc,
    output bqlp_pkg::ctrl_t           word
);
    import bqlp_pkg::*;

    always_comb
    begin
        word = CTRL_NOP;
        case (pc)
            STEP_WAIT:
            begin
                word.cond = COND_IN;
            end
            4'd1:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_A0; word.mul_b = MB_X;
            end
            4'd2:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_A1; word.mul_b = MB_X1;
                word.acc_op = ACC_LOAD; word.shift = SH_HIST;
            end
            4'd3:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_A0; word.mul_b = MB_X2;
                word.acc_op = ACC_ADD; word.shift = SH_HIST;
            end
            4'd4:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_B1; word.mul_b = MB_Y1_LO;
                word.acc_op = ACC_ADD; word.shift = SH_HIST;
            end
            4'd5:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_B1; word.mul_b = MB_Y1_HI;
                word.acc_op = ACC_SUB; word.shift = SH_NONE;
            end
            4'd6:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_B2; word.mul_b = MB_Y2_LO;
                word.acc_op = ACC_SUB; word.shift = SH_HALF;
            end
            4'd7:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_B2; word.mul_b = MB_Y2_HI;
                word.acc_op = ACC_SUB; word.shift = SH_NONE;
            end
            4'd8:
            begin
                word.acc_op = ACC_SUB; word.shift = SH_HALF;
            end
            4'd9:
            begin
                word.acc_op = ACC_RND_Y;
            end
            4'd10:
            begin
                word.sat_y = 1'b1;
            end
            4'd11:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_GAIN; word.mul_b = MB_YN_LO;
            end
            4'd12:
            begin
                word.mul_en = 1'b1; word.mul_a = MA_GAIN; word.mul_b = MB_YN_HI;
                word.acc_op = ACC_LOAD; word.shift = SH_NONE;
            end
            4'd13:
            begin
                word.acc_op = ACC_ADD; word.shift = SH_HALF;
            end
            4'd14:
            begin
                word.acc_op = ACC_RND_O;
            end
            STEP_EMIT:
            begin
                word.cond = COND_OUT; word.emit = 1'b1; word.jump = 1'b1;
            end
            default:
            begin
                word = CTRL_NOP;
            end
        endcase
    end

endmodule

@@ rtl/bqlp_sequencer.sv @@
// step counter with conditional hold and jump back to the wait step
`timescale 1ns / 1ps

module bqlp_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bqlp_pkg::ctrl_t           word,
    input  logic                      in_valid,
    input  logic                      out_busy,
    output logic [bqlp_pkg::PC_W-1:0] pc,
    output logic                      fire,
    output logic                      in_ready
);
    import bqlp_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    always_comb
    begin
        case (word.cond)
            COND_NONE: fire = 1'b1;
            COND_IN:   fire = in_valid;
            COND_OUT:  fire = !out_busy;
            default:   fire = 1'b1;
        endcase
    end

    always_comb
    begin
        if (!fire)
            pc_next = pc_reg;
        else if (word.jump)
            pc_next = STEP_WAIT;
        else
            pc_next = pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_WAIT;
        else
            pc_reg <= pc_next;
    end

    assign pc       = pc_reg;
    assign in_ready = (word.cond == COND_IN);

endmodule

@@ rtl/bqlp_datapath.sv @@
// shared multiplier, wide accumulator, rounding and saturation, sample history
`timescale 1ns / 1ps

module bqlp_datapath #(
    parameter int COEF_FRAC_BITS = 28,
    parameter int HIST_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bqlp_pkg::ctrl_t                      word,
    input  logic                                 fire,
    input  logic signed [bqlp_pkg::SAMPLE_W-1:0] sample_in,
    input  bqlp_pkg::cfg_t                       cfg,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0] res_sample
);
    import bqlp_pkg::*;

    localparam int OUT_SHIFT = HIST_FRAC_BITS + GAIN_FRAC;
    localparam logic signed [ACC_W-1:0] ONE_W = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] RND_Y_C = ONE_W << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] RND_O_C = ONE_W << (OUT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'(OUT_LIMIT);
    localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI;
    localparam logic signed [HIST_W-1:0] HIST_MAX = {1'b0, {(HIST_W-1){1'b1}}};
    localparam logic signed [HIST_W-1:0] HIST_MIN = {1'b1, {(HIST_W-1){1'b0}}};

    logic signed [SAMPLE_W-1:0] x_cur_reg;
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic signed [SAMPLE_W-1:0] x2_reg;
    logic signed [HIST_W-1:0]   y1_reg;
    logic signed [HIST_W-1:0]   y2_reg;
    logic signed [HIST_W-1:0]   yn_reg;
    logic signed [HIST_W-1:0]   yn_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    prod_sh;
    logic signed [ACC_W-1:0]    sh_y;
    logic signed [ACC_W-1:0]    sh_o;
    logic [ACC_W-HIST_W:0]      y_top;

    // operand selection
    always_comb
    begin
        case (word.mul_a)
            MA_A0:   mul_a = {cfg.a0[COEF_W-1], cfg.a0};
            MA_A1:   mul_a = {cfg.a1[COEF_W-1], cfg.a1};
            MA_B1:   mul_a = {cfg.b1[COEF_W-1], cfg.b1};
            MA_B2:   mul_a = {cfg.b2[COEF_W-1], cfg.b2};
            MA_GAIN: mul_a = {{(MUL_A_W-GAIN_W){1'b0}}, cfg.gain};
            default: mul_a = '0;
        endcase
    end

    // history words split into unsigned low half and signed high half
    always_comb
    begin
        case (word.mul_b)
            MB_X:     mul_b = {{(MUL_B_W-SAMPLE_W){x_cur_reg[SAMPLE_W-1]}}, x_cur_reg};
            MB_X1:    mul_b = {{(MUL_B_W-SAMPLE_W){x1_reg[SAMPLE_W-1]}}, x1_reg};
            MB_X2:    mul_b = {{(MUL_B_W-SAMPLE_W){x2_reg[SAMPLE_W-1]}}, x2_reg};
            MB_Y1_LO: mul_b = {1'b0, y1_reg[Y_SPLIT-1:0]};
            MB_Y1_HI: mul_b = {y1_reg[HIST_W-1], y1_reg[HIST_W-1:Y_SPLIT]};
            MB_Y2_LO: mul_b = {1'b0, y2_reg[Y_SPLIT-1:0]};
            MB_Y2_HI: mul_b = {y2_reg[HIST_W-1], y2_reg[HIST_W-1:Y_SPLIT]};
            MB_YN_LO: mul_b = {1'b0, yn_reg[Y_SPLIT-1:0]};
            MB_YN_HI: mul_b = {yn_reg[HIST_W-1], yn_reg[HIST_W-1:Y_SPLIT]};
            default:  mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (word.shift)
            SH_NONE: prod_sh = prod_ext;
            SH_HIST: prod_sh = prod_ext << HIST_FRAC_BITS;
            SH_HALF: prod_sh = prod_ext << Y_SPLIT;
            default: prod_sh = prod_ext;
        endcase
    end

    always_comb
    begin
        case (word.acc_op)
            ACC_NOP:   acc_next = acc_reg;
            ACC_LOAD:  acc_next = prod_sh;
            ACC_ADD:   acc_next = acc_reg + prod_sh;
            ACC_SUB:   acc_next = acc_reg - prod_sh;
            ACC_RND_Y: acc_next = acc_reg + RND_Y_C;
            ACC_RND_O: acc_next = acc_reg + RND_O_C;
            default:   acc_next = acc_reg;
        endcase
    end

    // new y: drop fraction bits, clamp to the history range
    assign sh_y  = acc_reg >>> COEF_FRAC_BITS;
    assign y_top = sh_y[ACC_W-1:HIST_W-1];

    always_comb
    begin
        if ((&y_top) || !(|y_top))
            yn_next = sh_y[HIST_W-1:0];
        else if (y_top[ACC_W-HIST_W])
            yn_next = HIST_MIN;
        else
            yn_next = HIST_MAX;
    end

    // gained sample: drop fraction bits, clamp to the output limit
    assign sh_o = acc_reg >>> OUT_SHIFT;

    always_comb
    begin
        if (sh_o > OUT_HI)
            res_sample = OUT_HI[SAMPLE_W-1:0];
        else if (sh_o < OUT_LO)
            res_sample = OUT_LO[SAMPLE_W-1:0];
        else
            res_sample = sh_o[SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (word.mul_en)
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (word.sat_y)
            yn_reg <= yn_next;
        if ((word.cond == COND_IN) && fire)
            x_cur_reg <= sample_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end
        else if (word.emit && fire)
        begin
            x2_reg <= x1_reg;
            x1_reg <= x_cur_reg;
            y2_reg <= y1_reg;
            y1_reg <= yn_reg;
        end
    end

endmodule

@@ rtl/biquad_lowpass_filter.sv @@
// top level of the biquad low-pass filter: config registers, output register, sequencer
`timescale 1ns / 1ps
// timing: the 16-step microprogram runs from the wait step to the emit step for each sample
// intake: a new sample is taken only back at the wait step, after the emit step; one shared
//   33x25 multiplier runs the nine partial products in steps 1 to 12
// reset: rst_n clears the step counter, output valid and sample history, and
//   loads the default coefficients and unity gain; no clearing pass

module biquad_lowpass_filter #(
    parameter int COEF_FRAC_BITS = 28,
    parameter int HIST_FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [bqlp_pkg::SAMPLE_W-1:0]   sample_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [bqlp_pkg::SAMPLE_W-1:0]   sample_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bqlp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bqlp_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import bqlp_pkg::*;

    cfg_t                       cfg_reg;
    ctrl_t                      word;
    logic [PC_W-1:0]            pc;
    logic                       fire;
    logic                       out_busy;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;
    logic signed [SAMPLE_W-1:0] res_sample;

    // config writes are always taken; unknown indexes fall through
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.a0   <= RST_COEF_A0;
            cfg_reg.a1   <= RST_COEF_A1;
            cfg_reg.b1   <= RST_COEF_B1;
            cfg_reg.b2   <= RST_COEF_B2;
            cfg_reg.gain <= RST_GAIN;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COEF_A0:  cfg_reg.a0   <= cfg_data;
                CFG_COEF_A1:  cfg_reg.a1   <= cfg_data;
                CFG_COEF_B1:  cfg_reg.b1   <= cfg_data;
                CFG_COEF_B2:  cfg_reg.b2   <= cfg_data;
                CFG_OUT_GAIN: cfg_reg.gain <= cfg_data[GAIN_W-1:0];
                default:      cfg_reg      <= cfg_reg;
            endcase
        end
    end

    // control word for the current step
    bqlp_ucode_rom u_rom (
        .pc   (pc),
        .word (word)
    );

    // emit step holds while the output register still has an untaken beat
    assign out_busy = out_valid_reg && !out_ready;

    bqlp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .word     (word),
        .in_valid (in_valid),
        .out_busy (out_busy),
        .pc       (pc),
        .fire     (fire),
        .in_ready (in_ready)
    );

    bqlp_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .HIST_FRAC_BITS (HIST_FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .word       (word),
        .fire       (fire),
        .sample_in  (sample_in),
        .cfg        (cfg_reg),
        .res_sample (res_sample)
    );

    // output register: lets the next sample start while this beat waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (word.emit && fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (word.emit && fire)
            sample_out_reg <= res_sample;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

    // a new output beat only comes from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        (word.emit && fire) || !(out_valid_reg && !$past(out_valid_reg))
            || $past(pc == STEP_EMIT))
        else $error("output beat raised outside the emit step");

    // an accepted input starts the program at its first compute step
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (pc == STEP_WAIT + PC_W'(1)))
        else $error("input beat did not start the program");

    // emitted samples stay within the saturation limit
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((sample_out <= 16'sd32765) && (sample_out >= -16'sd32765)))
        else $error("output sample beyond saturation limit");

endmodule

@@ tb/biquad_lowpass_filter_tb.sv @@
// self-checking testbench for the biquad low-pass filter: random beats, shadow filter, scoreboard
`timescale 1ns / 1ps

module biquad_lowpass_filter_tb;
    import bqlp_pkg::*;

    // fraction widths the block is built with, shared by the shadow filter
    localparam int COEF_FRAC = 28;
    localparam int HIST_FRAC = 16;

    // y history saturates to the signed 48-bit range
    localparam logic signed [127:0] HIST_TOP = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
    localparam logic signed [127:0] HIST_BOT = -(128'sd1 <<< (HIST_W - 1));

    // indexes past the last register, written to check that they are ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_OUT_GAIN + 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    localparam int RANDOM_PHASES    = 10;
    localparam int ITEMS_PER_PHASE  = 75;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MAX_REPORTS      = 10;

    // how a random phase picks its register values
    typedef enum logic [1:0] {
        SET_DEFAULT = 2'd0,
        SET_STABLE  = 2'd1,
        SET_WILD    = 2'd2,
        SET_EDGES   = 2'd3
    } setting_t;

    // shadow copy of the filter: registers, history and the expected samples
    class biquad_scoreboard;
        logic signed [COEF_W-1:0]   a0, a1, b1, b2;
        logic [GAIN_W-1:0]          gain;
        logic signed [SAMPLE_W-1:0] x1, x2;
        logic signed [HIST_W-1:0]   y1, y2;
        logic signed [SAMPLE_W-1:0] expected_samples[$];
        int                         errors;
        int                         reported;

        function new();
            a0 = RST_COEF_A0;
            a1 = RST_COEF_A1;
            b1 = RST_COEF_B1;
            b2 = RST_COEF_B2;
            gain = RST_GAIN;
            x1 = '0;
            x2 = '0;
            y1 = '0;
            y2 = '0;
            errors = 0;
            reported = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COEF_A0:  a0 = data;
                CFG_COEF_A1:  a1 = data;
                CFG_COEF_B1:  b1 = data;
                CFG_COEF_B2:  b2 = data;
                CFG_OUT_GAIN: gain = data[GAIN_W-1:0];
                default:      ;
            endcase
        endfunction

        // one filter step for an accepted input beat
        function void note_input(logic signed [SAMPLE_W-1:0] x);
            logic signed [127:0]        acc;
            logic signed [127:0]        scaled;
            logic signed [HIST_W-1:0]   y;
            logic signed [GAIN_W:0]     gain_s;
            logic signed [SAMPLE_W-1:0] res;
            acc = a0 * x + a1 * x1 + a0 * x2;
            acc = (acc <<< HIST_FRAC) - b1 * y1 - b2 * y2;
            acc = (acc + (128'sd1 <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
            if (acc > HIST_TOP)
                y = HIST_TOP[HIST_W-1:0];
            else if (acc < HIST_BOT)
                y = HIST_BOT[HIST_W-1:0];
            else
                y = acc[HIST_W-1:0];
            gain_s = {1'b0, gain};
            scaled = (y * gain_s + (128'sd1 <<< (HIST_FRAC + GAIN_FRAC - 1)))
                     >>> (HIST_FRAC + GAIN_FRAC);
            if (scaled > OUT_LIMIT)
                res = SAMPLE_W'(OUT_LIMIT);
            else if (scaled < -OUT_LIMIT)
                res = SAMPLE_W'(-OUT_LIMIT);
            else
                res = scaled[SAMPLE_W-1:0];
            expected_samples.push_back(res);
            x2 = x1;
            x1 = x;
            y2 = y1;
            y1 = y;
        endfunction

        function void check_output(logic signed [SAMPLE_W-1:0] actual);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_samples.size() == 0)
            begin
                errors++;
                if (reported < MAX_REPORTS)
                begin
                    reported++;
                    $display("unexpected sample_out %0d with nothing pending", actual);
                end
            end
            else
            begin
                want = expected_samples.pop_front();
                if (want !== actual)
                begin
                    errors++;
                    if (reported < MAX_REPORTS)
                    begin
                        reported++;
                        $display("sample_out mismatch: expected %0d, got %0d", want, actual);
                    end
                end
            end
        endfunction
    endclass

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic signed [SAMPLE_W-1:0]     sample_in = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]     sample_out;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;

    // both sides read these: no_idle makes a stretch without gaps,
    // long_hold asks the receiver for one long stall
    logic                           no_idle = 1'b0;
    int                             long_hold = 0;

    biquad_scoreboard               sb = new();

    biquad_lowpass_filter #(
        .COEF_FRAC_BITS(COEF_FRAC),
        .HIST_FRAC_BITS(HIST_FRAC)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample_out(sample_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // sample every handshake at the rising edge; the result is checked before
    // the new beat is noted so a stray result never eats a fresh expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (out_valid && out_ready)
                sb.check_output(sample_out);
            if (in_valid && in_ready)
                sb.note_input(sample_in);
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 12);
    endfunction

    // mostly full-range samples, with extremes and small values mixed in
    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value(logic [CFG_IDX_W-1:0] idx,
                                                             setting_t style);
        logic [CFG_DATA_W-1:0] v;
        v = $urandom;
        case (style)
            SET_DEFAULT:
                case (idx)
                    CFG_COEF_A0:  v = RST_COEF_A0;
                    CFG_COEF_A1:  v = RST_COEF_A1;
                    CFG_COEF_B1:  v = RST_COEF_B1;
                    CFG_COEF_B2:  v = RST_COEF_B2;
                    CFG_OUT_GAIN: v = {8'($urandom), RST_GAIN};
                    default:      ;
                endcase
            // a filter that stays bounded: |b1| <= 1, 0 <= b2 <= 0.75
            SET_STABLE:
                case (idx)
                    CFG_COEF_A0,
                    CFG_COEF_A1:  v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
                    CFG_COEF_B1:  v = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
                    CFG_COEF_B2:  v = $urandom_range(0, 32'h0C00_0000);
                    CFG_OUT_GAIN: v = {8'($urandom), 24'($urandom_range(0, 32'h0004_0000))};
                    default:      ;
                endcase
            SET_EDGES:
                case ($urandom_range(0, 4))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = 32'h0000_0000;
                    3:       v = 32'hFFFF_FFFF;
                    default: ;
                endcase
            default: ;
        endcase
        return v;
    endfunction

    // one input beat; valid only drops when a gap is drawn
    // a register write still pending from write_reg ends here
    task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
        int gap;
        cfg_valid <= 1'b0;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_in <= s;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    // cfg_valid stays up so writes can follow back to back
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        @(negedge clk);
    endtask

    // block is idle once every expected sample has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.expected_samples.size() != 0)
            @(negedge clk);
    endtask

    // receiver: random stalls, one long hold on request
    initial
    begin
        int hold_len;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold_len = (long_hold > 0) ? long_hold : draw_gap();
            long_hold = 0;
            if (hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // main sequence
    initial
    begin
        logic [CFG_IDX_W-1:0] order [5];
        setting_t             style;
        int                   first;
        order = '{CFG_COEF_A0, CFG_COEF_A1, CFG_COEF_B1, CFG_COEF_B2, CFG_OUT_GAIN};

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients: full-scale steps, zero, one lsb, alternating bits
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
        wait_drained();

        // extreme coefficients and gain: feedback of +8*y1 runs the
        // history into saturation and the output into the clip limits;
        // two spare indexes are written too and must change nothing
        write_reg(CFG_COEF_A0, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_A1, 32'h8000_0000);
        write_reg(CFG_COEF_B1, 32'h8000_0000);
        write_reg(CFG_COEF_B2, 32'h7FFF_FFFF);
        write_reg(CFG_OUT_GAIN, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_LO, 32'h0000_0000);
        write_reg(CFG_SPARE_HI, $urandom);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        wait_drained();

        // unity a0, other coefficients zero, half gain: output is (x + x2)/2, half-lsb ties round upward
        write_reg(CFG_COEF_A0, 32'h1000_0000);
        write_reg(CFG_COEF_A1, 32'h0000_0000);
        write_reg(CFG_COEF_B1, 32'h0000_0000);
        write_reg(CFG_COEF_B2, 32'h0000_0000);
        write_reg(CFG_OUT_GAIN, 32'h0000_8000);
        send_sample(16'sh0001);
        send_sample(16'shFFFF);
        send_sample(16'sh0003);
        send_sample(16'sh0000);
        wait_drained();

        // tiny a0: history rounding sits exactly on half an lsb at +/-2048
        write_reg(CFG_COEF_A0, 32'h0000_0001);
        write_reg(CFG_OUT_GAIN, 32'h0001_0000);
        send_sample(16'sh0800);
        send_sample(16'sh0000);
        send_sample(16'sh0000);
        send_sample(16'shF800);
        wait_drained();

        // random phases, each with its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 9))
                0, 1:       style = SET_DEFAULT;
                2, 3, 4, 5: style = SET_STABLE;
                6, 7:       style = SET_WILD;
                default:    style = SET_EDGES;
            endcase
            first = $urandom_range(0, 4);
            for (int k = 0; k < 5; k++)
                write_reg(order[(first + k) % 5], pick_reg_value(order[(first + k) % 5], style));
            if ($urandom_range(0, 2) == 0)
                write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), $urandom);

            no_idle = (phase % 3 == 1);
            // one phase stalls the output side long enough to back up the input
            if (phase == 3)
                long_hold = LONG_HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(draw_sample());
            wait_drained();
        end

        // allow for any stray beat after the last expected one
        repeat (40) @(negedge clk);
        if (sb.errors == 0 && sb.expected_samples.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bqlp_pkg.sv
rtl/bqlp_ucode_rom.sv
rtl/bqlp_sequencer.sv
rtl/bqlp_datapath.sv
rtl/biquad_lowpass_filter.sv
tb/biquad_lowpass_filter_tb.sv
